FILE: sv/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int unsigned SECTOR_SPAN = 600;
  localparam int unsigned FULL_SCALE  = 255;

  localparam logic [15:0] MASK_R = 16'hF800;
  localparam logic [15:0] MASK_G = 16'h07E0;
  localparam logic [15:0] MASK_B = 16'h001F;

  // floor(x/600) == (x*RECIP600) >> 28 for x*344 < 2^28, i.e. all x < 255*600
  localparam logic [18:0] RECIP600 = 19'd447393;
  localparam int unsigned SHIFT600 = 28;
  // floor(y/255) == (y*RECIP255) >> 24 for y*254 < 2^24, i.e. all 16-bit y
  localparam logic [16:0] RECIP255 = 17'd65794;
  localparam int unsigned SHIFT255 = 24;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef logic [9:0]  frac_t;
  typedef logic [17:0] prod18_t;

  typedef struct packed {
    sector_t sector;
    frac_t   frac;
  } hue_split_t;

  function automatic logic [7:0] div600(input prod18_t x);
    logic [36:0] prod;
    prod = {19'd0, x} * {18'd0, RECIP600};
    return prod[SHIFT600 +: 8];
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [32:0] prod;
    prod = {17'd0, y} * {16'd0, RECIP255};
    return prod[SHIFT255 +: 8];
  endfunction

endpackage

FILE: sv/hsvrgb_sector.sv
`timescale 1ns / 1ps

module hsvrgb_sector (
  input  logic [11:0]              hue,
  output hsvrgb_pkg::hue_split_t   split
);
  import hsvrgb_pkg::*;

  localparam logic [11:0] H1 = 12'(SECTOR_SPAN);
  localparam logic [11:0] H2 = 12'(2 * SECTOR_SPAN);
  localparam logic [11:0] H3 = 12'(3 * SECTOR_SPAN);
  localparam logic [11:0] H4 = 12'(4 * SECTOR_SPAN);
  localparam logic [11:0] H5 = 12'(5 * SECTOR_SPAN);
  localparam logic [11:0] H6 = 12'(6 * SECTOR_SPAN);

  // remainder is always below 600, so ten bits hold it
  logic [9:0] rem;

  // hue past a full turn wraps back into the first sector
  always_comb begin
    if (hue >= H6) begin
      split.sector = SEC_0;
      rem          = 10'(hue - H6);
    end else if (hue >= H5) begin
      split.sector = SEC_5;
      rem          = 10'(hue - H5);
    end else if (hue >= H4) begin
      split.sector = SEC_4;
      rem          = 10'(hue - H4);
    end else if (hue >= H3) begin
      split.sector = SEC_3;
      rem          = 10'(hue - H3);
    end else if (hue >= H2) begin
      split.sector = SEC_2;
      rem          = 10'(hue - H2);
    end else if (hue >= H1) begin
      split.sector = SEC_1;
      rem          = 10'(hue - H1);
    end else begin
      split.sector = SEC_0;
      rem          = hue[9:0];
    end
    split.frac = rem;
  end

endmodule

FILE: sv/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps

// HSV to RGB pixel converter.
// Input stream: one request per pixel carrying hue (tenths of a degree),
// saturation and value. Output stream: red, green, blue and the same color
// packed as RGB565. Each input request yields exactly one output request.
// Six register stages: sector split, saturation products, divide by 600,
// value products, divide by 255, sector select and pack. A request accepted
// into the sector-split register passes through each of these stages in order
// before it is presented on out_*.
// Throughput is one pixel per clock while out_tready stays high.
// Every stage carries its own valid bit and stalls only when it is full and
// the stage after it cannot take its data, so bubbles are squeezed out and
// in_tready stays high while the pipe still has an empty slot.
// A stalled output holds its data until taken; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; in-flight pixels are
// discarded.
module hsv_to_rgb_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // hue[11:0], saturation[19:12], brightness[27:20], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // red[7:0], green[15:8], blue[23:16], packed_565[39:24]
);
  import hsvrgb_pkg::*;

  localparam logic [9:0] SPAN10  = 10'(SECTOR_SPAN);
  localparam logic [7:0] SCALE8  = 8'(FULL_SCALE);

  hue_split_t split;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, out_vld_r;

  // stage 1
  sector_t s1_sec_r;
  frac_t   s1_frac_r;
  logic [7:0] s1_sat_r, s1_val_r;
  // stage 2
  sector_t s2_sec_r;
  prod18_t s2_sf_r, s2_sg_r;
  logic [7:0] s2_sat_r, s2_val_r;
  prod18_t s2_sf_nxt, s2_sg_nxt;
  // stage 3
  sector_t s3_sec_r;
  logic [7:0] s3_kp_r, s3_kq_r, s3_kt_r, s3_val_r;
  // stage 4
  sector_t s4_sec_r;
  logic [15:0] s4_yp_r, s4_yq_r, s4_yt_r;
  logic [7:0]  s4_val_r;
  // stage 5
  sector_t s5_sec_r;
  logic [7:0] s5_p_r, s5_q_r, s5_t_r, s5_val_r;
  // output
  logic [7:0]  red_nxt, green_nxt, blue_nxt;
  logic [15:0] pack_nxt;
  logic [7:0]  red_r, green_r, blue_r;
  logic [15:0] pack_r;

  hsvrgb_sector u_sector (
    .hue   (in_tdata[11:0]),
    .split (split)
  );

  assign rdy6      = !out_vld_r || out_tready;
  assign rdy5      = !s5_vld_r  || rdy6;
  assign rdy4      = !s4_vld_r  || rdy5;
  assign rdy3      = !s3_vld_r  || rdy4;
  assign rdy2      = !s2_vld_r  || rdy3;
  assign rdy1      = !s1_vld_r  || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r  <= in_tvalid;
      if (rdy2) s2_vld_r  <= s1_vld_r;
      if (rdy3) s3_vld_r  <= s2_vld_r;
      if (rdy4) s4_vld_r  <= s3_vld_r;
      if (rdy5) s5_vld_r  <= s4_vld_r;
      if (rdy6) out_vld_r <= s5_vld_r;
    end
  end

  always_comb begin
    s2_sf_nxt = {10'd0, s1_sat_r} * {8'd0, s1_frac_r};
    s2_sg_nxt = {10'd0, s1_sat_r} * {8'd0, SPAN10 - s1_frac_r};
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_sec_r  <= split.sector;
      s1_frac_r <= split.frac;
      s1_sat_r  <= in_tdata[19:12];
      s1_val_r  <= in_tdata[27:20];
    end
    if (rdy2 && s1_vld_r) begin
      s2_sec_r <= s1_sec_r;
      s2_sf_r  <= s2_sf_nxt;
      s2_sg_r  <= s2_sg_nxt;
      s2_sat_r <= s1_sat_r;
      s2_val_r <= s1_val_r;
    end
    if (rdy3 && s2_vld_r) begin
      s3_sec_r <= s2_sec_r;
      s3_kp_r  <= SCALE8 - s2_sat_r;
      s3_kq_r  <= SCALE8 - div600(s2_sf_r);
      s3_kt_r  <= SCALE8 - div600(s2_sg_r);
      s3_val_r <= s2_val_r;
    end
    if (rdy4 && s3_vld_r) begin
      s4_sec_r <= s3_sec_r;
      s4_yp_r  <= {8'd0, s3_val_r} * {8'd0, s3_kp_r};
      s4_yq_r  <= {8'd0, s3_val_r} * {8'd0, s3_kq_r};
      s4_yt_r  <= {8'd0, s3_val_r} * {8'd0, s3_kt_r};
      s4_val_r <= s3_val_r;
    end
    if (rdy5 && s4_vld_r) begin
      s5_sec_r <= s4_sec_r;
      s5_p_r   <= div255(s4_yp_r);
      s5_q_r   <= div255(s4_yq_r);
      s5_t_r   <= div255(s4_yt_r);
      s5_val_r <= s4_val_r;
    end
    if (rdy6 && s5_vld_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      pack_r  <= pack_nxt;
    end
  end

  always_comb begin
    unique case (s5_sec_r)
      SEC_0: begin
        red_nxt = s5_val_r; green_nxt = s5_t_r;   blue_nxt = s5_p_r;
      end
      SEC_1: begin
        red_nxt = s5_q_r;   green_nxt = s5_val_r; blue_nxt = s5_p_r;
      end
      SEC_2: begin
        red_nxt = s5_p_r;   green_nxt = s5_val_r; blue_nxt = s5_t_r;
      end
      SEC_3: begin
        red_nxt = s5_p_r;   green_nxt = s5_q_r;   blue_nxt = s5_val_r;
      end
      SEC_4: begin
        red_nxt = s5_t_r;   green_nxt = s5_p_r;   blue_nxt = s5_val_r;
      end
      default: begin
        red_nxt = s5_val_r; green_nxt = s5_p_r;   blue_nxt = s5_q_r;
      end
    endcase
    pack_nxt = ({red_nxt, 8'h00} & MASK_R)
             | ({5'd0, green_nxt, 3'd0} & MASK_G)
             | ({8'h00, 3'd0, blue_nxt[7:3]} & MASK_B);
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {pack_r, blue_r, green_r, red_r};

  // with the sink ready the whole chain must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // a full stage facing a stall keeps its item
  a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_vld_r && !rdy6) |=> s5_vld_r)
    else $error("stage 5 item lost under stall");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  a_pack_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:35] == out_tdata[7:3]
                     && out_tdata[34:29] == out_tdata[15:10]
                     && out_tdata[28:24] == out_tdata[23:19]))
    else $error("RGB565 word disagrees with components");

endmodule
